/* rtl/amplifier_power_sequencer_core_assert.svh */
// ----------------------------------------------------------------------------
// amplifier power sequencer assertion macros
// concurrent checks that compile away when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef AMPLIFIER_POWER_SEQUENCER_CORE_ASSERT_SVH
`define AMPLIFIER_POWER_SEQUENCER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define APS_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("aps assertion failed");
`define APS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("aps assertion failed");
`else
`define APS_ASSERT_SAME(label, clk, rst, ante, cons)
`define APS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* rtl/aps_pkg.sv */
// ----------------------------------------------------------------------------
// aps_pkg
// shared types, codes and reset values of the amplifier power sequencer
// ----------------------------------------------------------------------------
package aps_pkg;

  localparam int unsigned POLL_W    = 16;
  localparam int unsigned TIME_W    = 17;
  localparam int unsigned RETRY_W   = 2;
  localparam int unsigned STATE_W   = 4;
  localparam int unsigned OPCODE_W  = 2;
  localparam int unsigned CFG_IDX_W = 2;

  // opcodes
  localparam logic [OPCODE_W-1:0] OP_POLL      = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_START     = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_STOP      = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_EMERGENCY = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POLL_INTERVAL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_TIMEOUT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STANDBY_TIMEOUT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RETRIES     = 2'd3;

  // register reset values
  localparam logic [POLL_W-1:0]  POLL_INTERVAL_RST   = 16'd200;
  localparam logic [TIME_W-1:0]  STEP_TIMEOUT_RST    = 17'd2000;
  localparam logic [TIME_W-1:0]  STANDBY_TIMEOUT_RST = 17'd60000;
  localparam logic [RETRY_W-1:0] MAX_RETRIES_RST     = 2'd3;

  localparam logic [TIME_W-1:0] ELAPSED_MAX = '1;

  // sequencer states
  localparam logic [STATE_W-1:0] ST_IDLE         = 4'd0;
  localparam logic [STATE_W-1:0] ST_SET_REMOTE   = 4'd1;
  localparam logic [STATE_W-1:0] ST_WAIT_REMOTE  = 4'd2;
  localparam logic [STATE_W-1:0] ST_SET_AMP      = 4'd3;
  localparam logic [STATE_W-1:0] ST_WAIT_AMP     = 4'd4;
  localparam logic [STATE_W-1:0] ST_WAIT_STANDBY = 4'd5;
  localparam logic [STATE_W-1:0] ST_SET_HV       = 4'd6;
  localparam logic [STATE_W-1:0] ST_WAIT_HV      = 4'd7;
  localparam logic [STATE_W-1:0] ST_RESET_HV     = 4'd8;
  localparam logic [STATE_W-1:0] ST_WAIT_HV_OFF  = 4'd9;
  localparam logic [STATE_W-1:0] ST_RESET_AMP    = 4'd10;
  localparam logic [STATE_W-1:0] ST_WAIT_AMP_OFF = 4'd11;
  localparam logic [STATE_W-1:0] ST_DONE         = 4'd12;
  localparam logic [STATE_W-1:0] ST_ERROR        = 4'd13;

  typedef struct packed {
    logic [POLL_W-1:0]  poll_interval_ms;
    logic [TIME_W-1:0]  step_timeout_ms;
    logic [TIME_W-1:0]  standby_timeout_ms;
    logic [RETRY_W-1:0] max_retries;
  } aps_cfg_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic                remote_mode;
    logic                standby_ready;
    logic                status_hv_on;
    logic                status_amp_on;
  } aps_item_t;

  typedef struct packed {
    logic               pulse_remote;
    logic               pulse_amp;
    logic               pulse_hv;
    logic               finished;
    logic               success;
    logic [STATE_W-1:0] state_code;
    logic [RETRY_W-1:0] retries_used;
  } aps_result_t;

endpackage

/* rtl/aps_cfg_regs.sv */
// ----------------------------------------------------------------------------
// aps_cfg_regs
// configuration register file of the amplifier power sequencer
// ----------------------------------------------------------------------------
module aps_cfg_regs
  import aps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TIME_W-1:0]    cfg_data,
  output aps_cfg_t             cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.poll_interval_ms   <= POLL_INTERVAL_RST;
      cfg.step_timeout_ms    <= STEP_TIMEOUT_RST;
      cfg.standby_timeout_ms <= STANDBY_TIMEOUT_RST;
      cfg.max_retries        <= MAX_RETRIES_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_POLL_INTERVAL:   cfg.poll_interval_ms   <= cfg_data[POLL_W-1:0];
        REG_STEP_TIMEOUT:    cfg.step_timeout_ms    <= cfg_data;
        REG_STANDBY_TIMEOUT: cfg.standby_timeout_ms <= cfg_data;
        REG_MAX_RETRIES:     cfg.max_retries        <= cfg_data[RETRY_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* rtl/aps_seq.sv */
// ----------------------------------------------------------------------------
// aps_seq
// sequencer state, elapsed timer and retry counter with one-step update logic
// ----------------------------------------------------------------------------
module aps_seq
  import aps_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  aps_item_t   item,
  input  aps_cfg_t    cfg,
  output aps_result_t res
);

`include "amplifier_power_sequencer_core_assert.svh"

  logic [STATE_W-1:0] state;
  logic [STATE_W-1:0] state_next;
  logic [TIME_W-1:0]  elapsed;
  logic [TIME_W-1:0]  elapsed_next;
  logic [RETRY_W-1:0] retry;
  logic [RETRY_W-1:0] retry_next;

  logic [TIME_W:0]    sum;
  logic [TIME_W-1:0]  elapsed_inc;
  logic               step_expired;
  logic               standby_expired;
  logic               retry_ok;
  logic [RETRY_W-1:0] retry_inc;

  // saturating elapsed time for a poll tick
  assign sum             = {1'b0, elapsed} + {{(TIME_W+1-POLL_W){1'b0}}, cfg.poll_interval_ms};
  assign elapsed_inc     = sum[TIME_W] ? ELAPSED_MAX : sum[TIME_W-1:0];
  assign step_expired    = elapsed_inc > cfg.step_timeout_ms;
  assign standby_expired = elapsed_inc > cfg.standby_timeout_ms;
  assign retry_ok        = retry < cfg.max_retries;
  assign retry_inc       = retry + 1'b1;

  always_comb begin
    state_next       = state;
    elapsed_next     = elapsed;
    retry_next       = retry;
    res.pulse_remote = 1'b0;
    res.pulse_amp    = 1'b0;
    res.pulse_hv     = 1'b0;
    res.finished     = 1'b0;
    res.success      = 1'b0;

    unique case (item.opcode)
      OP_START: begin
        retry_next   = '0;
        elapsed_next = '0;
        state_next   = ST_SET_REMOTE;
      end
      OP_STOP: begin
        retry_next   = '0;
        elapsed_next = '0;
        state_next   = ST_RESET_HV;
      end
      OP_EMERGENCY: begin
        res.pulse_hv  = item.status_hv_on;
        res.pulse_amp = item.status_amp_on;
        elapsed_next  = '0;
        state_next    = ST_IDLE;
      end
      default: begin
        if (state != ST_IDLE) begin
          elapsed_next = elapsed_inc;
          unique case (state)
            ST_SET_REMOTE: begin
              res.pulse_remote = !item.remote_mode;
              elapsed_next     = '0;
              state_next       = ST_WAIT_REMOTE;
            end
            ST_WAIT_REMOTE: begin
              if (item.remote_mode) begin
                retry_next = '0;
                state_next = ST_SET_AMP;
              end else if (step_expired) begin
                if (retry_ok) begin
                  retry_next = retry_inc;
                  state_next = ST_SET_REMOTE;
                end else begin
                  state_next = ST_ERROR;
                end
              end
            end
            ST_SET_AMP: begin
              res.pulse_amp = !item.status_amp_on;
              elapsed_next  = '0;
              state_next    = ST_WAIT_AMP;
            end
            ST_WAIT_AMP: begin
              if (item.status_amp_on) begin
                retry_next   = '0;
                elapsed_next = '0;
                state_next   = ST_WAIT_STANDBY;
              end else if (step_expired) begin
                if (retry_ok) begin
                  retry_next = retry_inc;
                  state_next = ST_SET_AMP;
                end else begin
                  state_next = ST_ERROR;
                end
              end
            end
            ST_WAIT_STANDBY: begin
              if (item.standby_ready) begin
                retry_next = '0;
                state_next = ST_SET_HV;
              end else if (standby_expired) begin
                state_next = ST_ERROR;
              end
            end
            ST_SET_HV: begin
              res.pulse_hv = !item.status_hv_on;
              elapsed_next = '0;
              state_next   = ST_WAIT_HV;
            end
            ST_WAIT_HV: begin
              if (item.status_hv_on) begin
                retry_next = '0;
                state_next = ST_DONE;
              end else if (step_expired) begin
                if (retry_ok) begin
                  retry_next = retry_inc;
                  state_next = ST_SET_HV;
                end else begin
                  state_next = ST_ERROR;
                end
              end
            end
            ST_RESET_HV: begin
              res.pulse_hv = item.status_hv_on;
              elapsed_next = '0;
              state_next   = ST_WAIT_HV_OFF;
            end
            ST_WAIT_HV_OFF: begin
              if (!item.status_hv_on) begin
                retry_next = '0;
                state_next = ST_RESET_AMP;
              end else if (step_expired) begin
                if (retry_ok) begin
                  retry_next = retry_inc;
                  state_next = ST_RESET_HV;
                end else begin
                  state_next = ST_ERROR;
                end
              end
            end
            ST_RESET_AMP: begin
              res.pulse_amp = item.status_amp_on;
              elapsed_next  = '0;
              state_next    = ST_WAIT_AMP_OFF;
            end
            ST_WAIT_AMP_OFF: begin
              if (!item.status_amp_on) begin
                retry_next = '0;
                state_next = ST_DONE;
              end else if (step_expired) begin
                if (retry_ok) begin
                  retry_next = retry_inc;
                  state_next = ST_RESET_AMP;
                end else begin
                  state_next = ST_ERROR;
                end
              end
            end
            ST_DONE: begin
              res.finished = 1'b1;
              res.success  = 1'b1;
              state_next   = ST_IDLE;
            end
            default: begin
              // error, and any unused code, reports a failed finish
              res.finished = 1'b1;
              state_next   = ST_IDLE;
            end
          endcase
        end
      end
    endcase

    res.state_code   = state_next;
    res.retries_used = retry_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      elapsed <= '0;
      retry   <= '0;
    end else if (step) begin
      state   <= state_next;
      elapsed <= elapsed_next;
      retry   <= retry_next;
    end
  end

  `APS_ASSERT_SAME(a_state_legal, clk, rst, 1'b1, state <= ST_ERROR)
  `APS_ASSERT_NEXT(a_idle_poll_holds_time, clk, rst,
                   step && state == ST_IDLE && item.opcode == OP_POLL, $stable(elapsed))
  `APS_ASSERT_SAME(a_remote_pulse_state, clk, rst,
                   step && res.pulse_remote, state == ST_SET_REMOTE)

endmodule

/* rtl/amplifier_power_sequencer_core.sv */
// ----------------------------------------------------------------------------
// amplifier_power_sequencer_core
// power-up / power-down sequencer for an amplifier, one result per command
// ----------------------------------------------------------------------------
// each item passes the input register, then the result register
// 1 item per cycle is taken unless out_stall holds a full result register
// a stalled full result register holds back the input register and sequencer
// reset: synchronous; sequencer idle, elapsed time and retries zero,
// configuration registers back to their defaults, both stages empty
module amplifier_power_sequencer_core
  import aps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TIME_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [OPCODE_W-1:0]  opcode,
  input  logic                 remote_mode,
  input  logic                 standby_ready,
  input  logic                 status_hv_on,
  input  logic                 status_amp_on,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 pulse_remote,
  output logic                 pulse_amp,
  output logic                 pulse_hv,
  output logic                 finished,
  output logic                 success,
  output logic [STATE_W-1:0]   state_code,
  output logic [RETRY_W-1:0]   retries_used
);

`include "amplifier_power_sequencer_core_assert.svh"

  aps_cfg_t    cfg;
  aps_item_t   item;
  aps_result_t res;
  logic        in_full;
  logic        step;

  aps_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // the held item moves on when the result register is free or being emptied
  assign step     = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item.opcode         <= opcode;
      item.remote_mode    <= remote_mode;
      item.standby_ready  <= standby_ready;
      item.status_hv_on   <= status_hv_on;
      item.status_amp_on  <= status_amp_on;
    end
  end

  aps_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (item),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      pulse_remote <= res.pulse_remote;
      pulse_amp    <= res.pulse_amp;
      pulse_hv     <= res.pulse_hv;
      finished     <= res.finished;
      success      <= res.success;
      state_code   <= res.state_code;
      retries_used <= res.retries_used;
    end
  end

  `APS_ASSERT_SAME(a_success_needs_finish, clk, rst, out_valid && success, finished)
  `APS_ASSERT_SAME(a_finish_goes_idle, clk, rst, out_valid && finished, state_code == ST_IDLE)
  `APS_ASSERT_SAME(a_no_stall_when_out_free, clk, rst, in_full && !out_valid, !in_stall)

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the amplifier power sequencer core: a directed
// list of commands, then randomized power-up / power-down traffic against a
// simulated amplifier, each result checked against a cycle-free predictor
// ----------------------------------------------------------------------------
module tb;
  import aps_pkg::*;

  localparam int NUM_PHASES      = 9;
  localparam int ITEMS_PER_PHASE = 217;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int DRAIN_CYCLES    = 4;
  localparam int MAX_PRINTED     = 100;

  typedef struct {
    aps_item_t   item;
    bit          typed;
    aps_result_t want;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TIME_W-1:0]    cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [OPCODE_W-1:0]  opcode = OP_POLL;
  logic                 remote_mode = 1'b0;
  logic                 standby_ready = 1'b0;
  logic                 status_hv_on = 1'b0;
  logic                 status_amp_on = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 pulse_remote;
  logic                 pulse_amp;
  logic                 pulse_hv;
  logic                 finished;
  logic                 success;
  logic [STATE_W-1:0]   state_code;
  logic [RETRY_W-1:0]   retries_used;

  amplifier_power_sequencer_core dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .opcode(opcode),
    .remote_mode(remote_mode),
    .standby_ready(standby_ready),
    .status_hv_on(status_hv_on),
    .status_amp_on(status_amp_on),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .pulse_remote(pulse_remote),
    .pulse_amp(pulse_amp),
    .pulse_hv(pulse_hv),
    .finished(finished),
    .success(success),
    .state_code(state_code),
    .retries_used(retries_used)
  );

  // predictor copy of the sequencer
  logic [POLL_W-1:0]  cfg_poll      = POLL_INTERVAL_RST;
  logic [TIME_W-1:0]  cfg_step      = STEP_TIMEOUT_RST;
  logic [TIME_W-1:0]  cfg_standby   = STANDBY_TIMEOUT_RST;
  logic [RETRY_W-1:0] cfg_retry_max = MAX_RETRIES_RST;
  logic [STATE_W-1:0] seq_st        = ST_IDLE;
  logic [TIME_W-1:0]  seq_elapsed   = '0;
  logic [RETRY_W-1:0] seq_retries   = '0;

  // simulated amplifier, toggles a status bit some polls after its pulse
  bit sim_remote, sim_standby, sim_hv, sim_amp;
  int dly_remote = -1, dly_standby = -1, dly_hv = -1, dly_amp = -1;

  aps_result_t pending_results[$];
  stim_row_t   dir_rows[$];
  int unsigned cfg_plan[NUM_PHASES][4];
  int          send_pct;
  int          recv_pct;
  int          error_count;
  int          result_count;
  int          cycle_count;

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_pct);
  end

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    if (error_count < MAX_PRINTED)
      $display("mismatch on result %0d, %s: got %0d, want %0d", result_count, what, got, want);
    error_count++;
  endtask

  task automatic check_result();
    aps_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("no result pending, state_code", int'(state_code), 0);
    end else begin
      want = pending_results.pop_front();
      if (pulse_remote !== want.pulse_remote)
        report_mismatch("pulse_remote", int'(pulse_remote), int'(want.pulse_remote));
      if (pulse_amp !== want.pulse_amp)
        report_mismatch("pulse_amp", int'(pulse_amp), int'(want.pulse_amp));
      if (pulse_hv !== want.pulse_hv)
        report_mismatch("pulse_hv", int'(pulse_hv), int'(want.pulse_hv));
      if (finished !== want.finished)
        report_mismatch("finished", int'(finished), int'(want.finished));
      if (success !== want.success)
        report_mismatch("success", int'(success), int'(want.success));
      if (state_code !== want.state_code)
        report_mismatch("state_code", int'(state_code), int'(want.state_code));
      if (retries_used !== want.retries_used)
        report_mismatch("retries_used", int'(retries_used), int'(want.retries_used));
    end
    result_count++;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) check_result();
  end

  function automatic void retry_or_fail(logic [STATE_W-1:0] resend);
    if (seq_retries < cfg_retry_max) begin
      seq_retries = seq_retries + 1'b1;
      seq_st = resend;
    end else begin
      seq_st = ST_ERROR;
    end
  endfunction

  function automatic aps_result_t predict_power_step(aps_item_t it);
    aps_result_t r;
    logic [TIME_W:0] sum;
    r = '0;
    case (it.opcode)
      OP_START: begin
        seq_retries = '0;
        seq_elapsed = '0;
        seq_st = ST_SET_REMOTE;
      end
      OP_STOP: begin
        seq_retries = '0;
        seq_elapsed = '0;
        seq_st = ST_RESET_HV;
      end
      OP_EMERGENCY: begin
        r.pulse_hv = it.status_hv_on;
        r.pulse_amp = it.status_amp_on;
        seq_elapsed = '0;
        seq_st = ST_IDLE;
      end
      default: begin
        if (seq_st != ST_IDLE) begin
          sum = {1'b0, seq_elapsed} + {2'b00, cfg_poll};
          seq_elapsed = (sum > {1'b0, ELAPSED_MAX}) ? ELAPSED_MAX : sum[TIME_W-1:0];
          case (seq_st)
            ST_SET_REMOTE: begin
              r.pulse_remote = !it.remote_mode;
              seq_elapsed = '0;
              seq_st = ST_WAIT_REMOTE;
            end
            ST_WAIT_REMOTE: begin
              if (it.remote_mode) begin
                seq_retries = '0;
                seq_st = ST_SET_AMP;
              end else if (seq_elapsed > cfg_step) begin
                retry_or_fail(ST_SET_REMOTE);
              end
            end
            ST_SET_AMP: begin
              r.pulse_amp = !it.status_amp_on;
              seq_elapsed = '0;
              seq_st = ST_WAIT_AMP;
            end
            ST_WAIT_AMP: begin
              if (it.status_amp_on) begin
                seq_retries = '0;
                seq_elapsed = '0;
                seq_st = ST_WAIT_STANDBY;
              end else if (seq_elapsed > cfg_step) begin
                retry_or_fail(ST_SET_AMP);
              end
            end
            ST_WAIT_STANDBY: begin
              if (it.standby_ready) begin
                seq_retries = '0;
                seq_st = ST_SET_HV;
              end else if (seq_elapsed > cfg_standby) begin
                seq_st = ST_ERROR;
              end
            end
            ST_SET_HV: begin
              r.pulse_hv = !it.status_hv_on;
              seq_elapsed = '0;
              seq_st = ST_WAIT_HV;
            end
            ST_WAIT_HV: begin
              if (it.status_hv_on) begin
                seq_retries = '0;
                seq_st = ST_DONE;
              end else if (seq_elapsed > cfg_step) begin
                retry_or_fail(ST_SET_HV);
              end
            end
            ST_RESET_HV: begin
              r.pulse_hv = it.status_hv_on;
              seq_elapsed = '0;
              seq_st = ST_WAIT_HV_OFF;
            end
            ST_WAIT_HV_OFF: begin
              if (!it.status_hv_on) begin
                seq_retries = '0;
                seq_st = ST_RESET_AMP;
              end else if (seq_elapsed > cfg_step) begin
                retry_or_fail(ST_RESET_HV);
              end
            end
            ST_RESET_AMP: begin
              r.pulse_amp = it.status_amp_on;
              seq_elapsed = '0;
              seq_st = ST_WAIT_AMP_OFF;
            end
            ST_WAIT_AMP_OFF: begin
              if (!it.status_amp_on) begin
                seq_retries = '0;
                seq_st = ST_DONE;
              end else if (seq_elapsed > cfg_step) begin
                retry_or_fail(ST_RESET_AMP);
              end
            end
            ST_DONE: begin
              r.finished = 1'b1;
              r.success = 1'b1;
              seq_st = ST_IDLE;
            end
            default: begin
              r.finished = 1'b1;
              r.success = 1'b0;
              seq_st = ST_IDLE;
            end
          endcase
        end
      end
    endcase
    r.state_code = seq_st;
    r.retries_used = seq_retries;
    return r;
  endfunction

  function automatic aps_result_t mk_res(bit pr, bit pa, bit ph, bit fin, bit ok,
                                         logic [STATE_W-1:0] st, logic [RETRY_W-1:0] ret);
    aps_result_t r;
    r.pulse_remote = pr;
    r.pulse_amp = pa;
    r.pulse_hv = ph;
    r.finished = fin;
    r.success = ok;
    r.state_code = st;
    r.retries_used = ret;
    return r;
  endfunction

  // status is {remote, standby, hv, amp}
  function automatic void add_row(logic [OPCODE_W-1:0] op, logic [3:0] status, bit typed,
                                  aps_result_t want);
    stim_row_t row;
    row.item.opcode = op;
    {row.item.remote_mode, row.item.standby_ready,
     row.item.status_hv_on, row.item.status_amp_on} = status;
    row.typed = typed;
    row.want = want;
    dir_rows.push_back(row);
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic push_item(aps_item_t it, aps_result_t want);
    while ($urandom_range(0, 99) < send_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode <= it.opcode;
    remote_mode <= it.remote_mode;
    standby_ready <= it.standby_ready;
    status_hv_on <= it.status_hv_on;
    status_amp_on <= it.status_amp_on;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(want);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_settings(int ph);
    logic [TIME_W-1:0] data;
    for (int i = 0; i < 4; i++) begin
      data = TIME_W'(cfg_plan[ph][i]);
      // bits above the register width must be dropped
      if (i == REG_POLL_INTERVAL) data[TIME_W-1] = 1'($urandom);
      if (i == REG_MAX_RETRIES) data[TIME_W-1:RETRY_W] = 15'($urandom);
      cfg_valid <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data <= data;
      do @(posedge clk); while (!cfg_ready);
      case (CFG_IDX_W'(i))
        REG_POLL_INTERVAL:   cfg_poll = data[POLL_W-1:0];
        REG_STEP_TIMEOUT:    cfg_step = data;
        REG_STANDBY_TIMEOUT: cfg_standby = data;
        default:             cfg_retry_max = data[RETRY_W-1:0];
      endcase
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic bit delay_expired(inout int d);
    if (d == 0) begin
      d = -1;
      return 1'b1;
    end
    if (d > 0) d--;
    return 1'b0;
  endfunction

  function automatic void schedule_toggle(inout int d);
    if (d < 0 && $urandom_range(0, 99) < 85) d = int'($urandom_range(0, 9));
  endfunction

  function automatic void amp_tick();
    bit amp_before;
    amp_before = sim_amp;
    if (delay_expired(dly_remote)) sim_remote = !sim_remote;
    if (delay_expired(dly_hv)) sim_hv = !sim_hv;
    if (delay_expired(dly_amp)) sim_amp = !sim_amp;
    if (delay_expired(dly_standby)) sim_standby = 1'b1;
    if (sim_amp && !amp_before) begin
      // warm-up, sometimes never reaching standby
      dly_standby = ($urandom_range(0, 99) < 90) ? int'($urandom_range(0, 12)) : -1;
    end
    if (!sim_amp) begin
      sim_standby = 1'b0;
      dly_standby = -1;
    end
  endfunction

  task automatic random_item(output bit counted);
    aps_item_t   it;
    aps_result_t r;
    int unsigned roll;
    bit          was_idle;
    was_idle = (seq_st == ST_IDLE);
    amp_tick();
    roll = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 8) begin
      it.opcode = OPCODE_W'($urandom);
      it.remote_mode = 1'($urandom);
      it.standby_ready = 1'($urandom);
      it.status_hv_on = 1'($urandom);
      it.status_amp_on = 1'($urandom);
    end else begin
      if (was_idle)
        it.opcode = roll < 50 ? OP_START : roll < 80 ? OP_STOP :
                    roll < 92 ? OP_POLL : OP_EMERGENCY;
      else
        it.opcode = roll < 95 ? OP_POLL : roll < 97 ? OP_START :
                    roll < 99 ? OP_STOP : OP_EMERGENCY;
      it.remote_mode = sim_remote ^ ($urandom_range(0, 99) < 3);
      it.standby_ready = sim_standby ^ ($urandom_range(0, 99) < 3);
      it.status_hv_on = sim_hv ^ ($urandom_range(0, 99) < 3);
      it.status_amp_on = sim_amp ^ ($urandom_range(0, 99) < 3);
    end
    r = predict_power_step(it);
    if (r.pulse_remote) schedule_toggle(dly_remote);
    if (r.pulse_hv) schedule_toggle(dly_hv);
    if (r.pulse_amp) schedule_toggle(dly_amp);
    push_item(it, r);
    counted = !(was_idle && it.opcode == OP_POLL);
  endtask

  initial begin
    aps_result_t r;
    bit          counted;
    int          rnd_count;
    int          done_in_phase;

    send_pct = 23;
    recv_pct = 55;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // status columns: remote, standby, hv, amp
    add_row(OP_POLL,      4'b0000, 1'b1,
            mk_res(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ST_IDLE, 2'd0));
    add_row(OP_POLL,      4'b1111, 1'b1,
            mk_res(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ST_IDLE, 2'd0));
    add_row(OP_EMERGENCY, 4'b1111, 1'b1,
            mk_res(1'b0, 1'b1, 1'b1, 1'b0, 1'b0, ST_IDLE, 2'd0));
    add_row(OP_EMERGENCY, 4'b0000, 1'b1,
            mk_res(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ST_IDLE, 2'd0));
    add_row(OP_START,     4'b0000, 1'b1,
            mk_res(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ST_SET_REMOTE, 2'd0));
    add_row(OP_POLL,      4'b0000, 1'b0, '0);
    add_row(OP_POLL,      4'b1000, 1'b0, '0);
    add_row(OP_POLL,      4'b1000, 1'b0, '0);
    add_row(OP_POLL,      4'b1001, 1'b0, '0);
    add_row(OP_POLL,      4'b1101, 1'b0, '0);
    add_row(OP_POLL,      4'b1101, 1'b0, '0);
    add_row(OP_POLL,      4'b1111, 1'b0, '0);
    add_row(OP_POLL,      4'b1111, 1'b1,
            mk_res(1'b0, 1'b0, 1'b0, 1'b1, 1'b1, ST_IDLE, 2'd0));
    add_row(OP_STOP,      4'b1111, 1'b1,
            mk_res(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ST_RESET_HV, 2'd0));
    add_row(OP_POLL,      4'b1111, 1'b0, '0);
    add_row(OP_POLL,      4'b1101, 1'b0, '0);
    add_row(OP_POLL,      4'b1101, 1'b0, '0);
    add_row(OP_POLL,      4'b1100, 1'b0, '0);
    add_row(OP_POLL,      4'b0000, 1'b1,
            mk_res(1'b0, 1'b0, 1'b0, 1'b1, 1'b1, ST_IDLE, 2'd0));
    add_row(OP_START,     4'b1111, 1'b1,
            mk_res(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ST_SET_REMOTE, 2'd0));
    add_row(OP_POLL,      4'b1111, 1'b0, '0);
    // restart and stop while a sequence is running
    add_row(OP_START,     4'b0110, 1'b1,
            mk_res(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ST_SET_REMOTE, 2'd0));
    add_row(OP_STOP,      4'b0011, 1'b1,
            mk_res(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ST_RESET_HV, 2'd0));
    add_row(OP_EMERGENCY, 4'b0010, 1'b1,
            mk_res(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, ST_IDLE, 2'd0));
    add_row(OP_POLL,      4'b0101, 1'b1,
            mk_res(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ST_IDLE, 2'd0));

    foreach (dir_rows[i]) begin
      r = predict_power_step(dir_rows[i].item);
      push_item(dir_rows[i].item, dir_rows[i].typed ? dir_rows[i].want : r);
    end

    // poll, step timeout, standby timeout, retries
    cfg_plan[0] = '{POLL_INTERVAL_RST, STEP_TIMEOUT_RST, STANDBY_TIMEOUT_RST, MAX_RETRIES_RST};
    cfg_plan[1] = '{65535, 0, 0, 0};
    cfg_plan[2] = '{65535, 131071, 131071, 3};
    cfg_plan[3] = '{0, 1, 1, 1};
    cfg_plan[4] = '{1, 1, 1, 3};
    cfg_plan[5] = '{500, 1500, 6000, 2};
    cfg_plan[6] = '{$urandom_range(1, 4000), $urandom_range(0, 20000),
                    $urandom_range(0, 60000), $urandom_range(0, 3)};
    cfg_plan[7] = '{65535, 131070, 131071, 1};
    cfg_plan[8] = '{POLL_INTERVAL_RST, STEP_TIMEOUT_RST, STANDBY_TIMEOUT_RST, MAX_RETRIES_RST};

    rnd_count = 0;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      if (ph != 0) write_settings(ph);
      done_in_phase = 0;
      while (done_in_phase < ITEMS_PER_PHASE) begin
        if (rnd_count < 650) begin
          send_pct = 23;
          recv_pct = 55;
        end else if (rnd_count < 1300) begin
          send_pct = 55;
          recv_pct = 23;
        end else begin
          send_pct = 0;
          recv_pct = 0;
        end
        random_item(counted);
        if (counted) begin
          done_in_phase++;
          rnd_count++;
        end
      end
    end

    wait_idle();
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/aps_pkg.sv
rtl/aps_cfg_regs.sv
rtl/aps_seq.sv
rtl/amplifier_power_sequencer_core.sv
tb/tb.sv
